// ----- rtl/core/icmper_pkg.sv -----
// Shared types, constants and helpers for the ICMP receive path and echo responder.
// Depends on nothing; used by every module under rtl/core.
package icmper_pkg;

    localparam int COUNT_W     = 11;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 64;
    localparam int QDEPTH      = 2;

    localparam logic [COUNT_W-1:0] MAX_MSG_BYTES_DEF = 11'd1480;
    localparam logic [COUNT_W-1:0] COUNT_MAX         = 11'd2047;
    localparam logic [COUNT_W-1:0] HDR_LAST_POS      = 11'd7;
    localparam logic [COUNT_W-1:0] BODY_START_POS    = 11'd4;

    localparam logic [15:0] ECHO_IDENT = 16'h4b4f;
    localparam logic [15:0] SUM_GOOD   = 16'hffff;

    localparam logic [7:0] T_ECHO_REPLY = 8'd0;
    localparam logic [7:0] T_UNREACH    = 8'd3;
    localparam logic [7:0] T_ECHO_REQ   = 8'd8;
    localparam logic [7:0] T_TIME_EXC   = 8'd11;

    localparam logic [3:0] V_MID       = 4'd0;
    localparam logic [3:0] V_DROP      = 4'd1;
    localparam logic [3:0] V_REPLY     = 4'd2;
    localparam logic [3:0] V_TOO_LONG  = 4'd3;
    localparam logic [3:0] V_MATCHED   = 4'd4;
    localparam logic [3:0] V_UNMATCHED = 4'd5;
    localparam logic [3:0] V_UNREACH   = 4'd6;
    localparam logic [3:0] V_TIME_EXC  = 4'd7;
    localparam logic [3:0] V_OTHER     = 4'd8;

    localparam logic [CFG_INDEX_W-1:0] REG_WAITER_ARMED = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAITER_DEST  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WAITER_SEQ   = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAITER_SENT  = 8'd3;

    // One classified byte on its way from front to back.
    // kind carries V_MATCHED for an echo reply with our identifier: the back end
    // settles it against the waiter.
    typedef struct packed {
        logic [7:0]  reply_byte;
        logic        is_last;
        logic [3:0]  kind;
        logic [15:0] csum;
        logic [15:0] seq;
        logic [31:0] src;
        logic [63:0] now;
    } item_t;

    // Ones'-complement add with end-around carry
    function automatic logic [15:0] oc_add(input logic [15:0] s, input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, v};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

// ----- rtl/core/icmp_receive_echo_responder.sv -----
// Top level of the ICMP receive path with echo responder.
// Depends on icmper_pkg, icmper_front, icmper_queue and icmper_back.
//
//  Channel  Handshake              Payload
//  in       in_valid / in_ready    data_byte, last_byte, source_addr, now_tick
//  out      out_valid / out_ready  reply_byte, reply_last, verdict, reply_checksum,
//                                  round_trip, match_count
//  cfg      cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
//  One byte per cycle while the queue has room; each byte needs two 16-bit end-around-carry
//  adds in the front end (whole message and body), and the back end does one 64-bit subtract per result.
//  After its byte is accepted, a result passes through the queue, then the output register.
//  Reset clears all message state, the waiter registers and the match count.
//  A stalled output fills the two-entry queue; in_ready drops only when it is full.
module icmp_receive_echo_responder #(
    parameter logic [icmper_pkg::COUNT_W-1:0] MAX_MSG_BYTES = icmper_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [7:0]                         data_byte,
    input  logic                               last_byte,
    input  logic [31:0]                        source_addr,
    input  logic [63:0]                        now_tick,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         reply_byte,
    output logic                               reply_last,
    output logic [3:0]                         verdict,
    output logic [15:0]                        reply_checksum,
    output logic [63:0]                        round_trip,
    output logic [31:0]                        match_count,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [icmper_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [icmper_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import icmper_pkg::*;

    logic  push_valid, push_ready;
    logic  pop_valid, pop_ready;
    item_t push_item, pop_item;

    assign cfg_ready = 1'b1;

    icmper_front #(
        .MAX_MSG_BYTES (MAX_MSG_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .source_addr (source_addr),
        .now_tick    (now_tick),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_item   (push_item)
    );

    icmper_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    icmper_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .reply_byte     (reply_byte),
        .reply_last     (reply_last),
        .verdict        (verdict),
        .reply_checksum (reply_checksum),
        .round_trip     (round_trip),
        .match_count    (match_count)
    );

endmodule

// ----- rtl/core/icmper_front.sv -----
// Front end: takes message bytes, keeps checksums and header fields, classifies
// the last byte. Depends on icmper_pkg.
module icmper_front #(
    parameter logic [icmper_pkg::COUNT_W-1:0] MAX_MSG_BYTES = icmper_pkg::MAX_MSG_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [31:0]         source_addr,
    input  logic [63:0]         now_tick,
    output logic                push_valid,
    input  logic                push_ready,
    output icmper_pkg::item_t   push_item
);
    import icmper_pkg::*;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        sum_all_reg, sum_all_next;
    logic [15:0]        sum_body_reg, sum_body_next;
    logic [7:0]         msg_type_reg, msg_type_next;
    logic [7:0]         msg_code_reg, msg_code_next;
    logic [15:0]        ident_reg, ident_next;
    logic [15:0]        seq_reg, seq_next;

    logic [COUNT_W-1:0] pos;
    logic [15:0]        word_val;
    logic [15:0]        sum_all_upd, sum_body_upd;
    logic               accept;

    assign pos        = byte_count_reg;
    assign accept     = in_valid && in_ready;
    assign in_ready   = push_ready;
    assign push_valid = in_valid;

    // even offsets are high bytes, odd offsets low; a saturated count is odd
    assign word_val    = pos[0] ? {8'd0, data_byte} : {data_byte, 8'd0};
    assign sum_all_upd = oc_add(sum_all_reg, word_val);
    assign sum_body_upd = (pos >= BODY_START_POS) ? oc_add(sum_body_reg, word_val)
                                                  : sum_body_reg;

    always_comb
    begin
        logic [7:0]  typ;
        logic [7:0]  cod;
        logic [15:0] idn;
        logic [15:0] sq;

        typ = (pos == 11'd0) ? data_byte : msg_type_reg;
        cod = (pos == 11'd1) ? data_byte : msg_code_reg;
        idn = ident_reg;
        sq  = seq_reg;
        if (pos == 11'd4) idn[15:8] = data_byte;
        if (pos == 11'd5) idn[7:0]  = data_byte;
        if (pos == 11'd6) sq[15:8]  = data_byte;
        if (pos == 11'd7) sq[7:0]   = data_byte;

        push_item.reply_byte = (pos inside {11'd0, 11'd2, 11'd3}) ? 8'd0 : data_byte;
        push_item.is_last    = last_byte;
        push_item.csum       = 16'd0;
        push_item.seq        = sq;
        push_item.src        = source_addr;
        push_item.now        = now_tick;
        push_item.kind       = V_MID;

        if (last_byte)
        begin
            if (pos < HDR_LAST_POS || sum_all_upd != SUM_GOOD)
                push_item.kind = V_DROP;
            else if (typ == T_ECHO_REQ && cod == 8'd0)
            begin
                // length above limit: pos + 1 > MAX
                if (pos >= MAX_MSG_BYTES)
                    push_item.kind = V_TOO_LONG;
                else
                begin
                    push_item.kind = V_REPLY;
                    push_item.csum = ~sum_body_upd;
                end
            end
            else if (typ == T_ECHO_REPLY && cod == 8'd0)
                push_item.kind = (idn == ECHO_IDENT) ? V_MATCHED : V_UNMATCHED;
            else if (typ == T_UNREACH)
                push_item.kind = V_UNREACH;
            else if (typ == T_TIME_EXC)
                push_item.kind = V_TIME_EXC;
            else
                push_item.kind = V_OTHER;
        end

        byte_count_next = byte_count_reg;
        sum_all_next    = sum_all_reg;
        sum_body_next   = sum_body_reg;
        msg_type_next   = msg_type_reg;
        msg_code_next   = msg_code_reg;
        ident_next      = ident_reg;
        seq_next        = seq_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                byte_count_next = '0;
                sum_all_next    = '0;
                sum_body_next   = '0;
                msg_type_next   = '0;
                msg_code_next   = '0;
                ident_next      = '0;
                seq_next        = '0;
            end
            else
            begin
                if (byte_count_reg < COUNT_MAX)
                    byte_count_next = byte_count_reg + 11'd1;
                sum_all_next  = sum_all_upd;
                sum_body_next = sum_body_upd;
                msg_type_next = typ;
                msg_code_next = cod;
                ident_next    = idn;
                seq_next      = sq;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            sum_all_reg    <= '0;
            sum_body_reg   <= '0;
            msg_type_reg   <= '0;
            msg_code_reg   <= '0;
            ident_reg      <= '0;
            seq_reg        <= '0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            sum_all_reg    <= sum_all_next;
            sum_body_reg   <= sum_body_next;
            msg_type_reg   <= msg_type_next;
            msg_code_reg   <= msg_code_next;
            ident_reg      <= ident_next;
            seq_reg        <= seq_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> byte_count_reg == '0 && sum_all_reg == '0)
        else $error("message state not cleared after last byte");

endmodule

// ----- rtl/core/icmper_queue.sv -----
// Short request queue between front and back end, built from flops.
// Depends on icmper_pkg (item_t, QDEPTH).
module icmper_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  icmper_pkg::item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output icmper_pkg::item_t pop_item
);
    import icmper_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

    item_t            slot_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

endmodule

// ----- rtl/core/icmper_back.sv -----
// Back end: waiter registers, echo reply matching, round-trip time, match count
// and the output register. Depends on icmper_pkg.
module icmper_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [icmper_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [icmper_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                               pop_valid,
    output logic                               pop_ready,
    input  icmper_pkg::item_t                  pop_item,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         reply_byte,
    output logic                               reply_last,
    output logic [3:0]                         verdict,
    output logic [15:0]                        reply_checksum,
    output logic [63:0]                        round_trip,
    output logic [31:0]                        match_count
);
    import icmper_pkg::*;

    logic        armed_reg;
    logic [31:0] dest_reg;
    logic [15:0] wseq_reg;
    logic [63:0] sent_reg;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [3:0]  verdict_reg, verdict_next;
    logic [15:0] csum_reg;
    logic [63:0] rtt_reg, rtt_next;
    logic [31:0] count_reg, count_next;
    logic        load, hit;

    assign pop_ready = !out_valid_reg || out_ready;
    assign load      = pop_valid && pop_ready;
    assign hit       = armed_reg && pop_item.src == dest_reg && pop_item.seq == wseq_reg;

    always_comb
    begin
        verdict_next = pop_item.kind;
        rtt_next     = '0;
        count_next   = count_reg;
        if (pop_item.kind == V_MATCHED)
        begin
            if (hit)
            begin
                rtt_next = pop_item.now - sent_reg;
                if (load)
                    count_next = count_reg + 32'd1;
            end
            else
                verdict_next = V_UNMATCHED;
        end

        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // waiter registers; the user must write them only while the block is idle, the block does not enforce it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg <= 1'b0;
            dest_reg  <= '0;
            wseq_reg  <= '0;
            sent_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_WAITER_ARMED: armed_reg <= cfg_data[0];
                REG_WAITER_DEST:  dest_reg  <= cfg_data[31:0];
                REG_WAITER_SEQ:   wseq_reg  <= cfg_data[15:0];
                REG_WAITER_SENT:  sent_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= pop_item.reply_byte;
            last_reg    <= pop_item.is_last;
            verdict_reg <= verdict_next;
            csum_reg    <= pop_item.csum;
            rtt_reg     <= rtt_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign reply_byte     = byte_reg;
    assign reply_last     = last_reg;
    assign verdict        = verdict_reg;
    assign reply_checksum = csum_reg;
    assign round_trip     = rtt_reg;
    assign match_count    = count_reg;

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        load && verdict_next == V_MATCHED |=> count_reg == $past(count_reg) + 32'd1)
        else $error("match count did not advance on a matched reply");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(load && verdict_next == V_MATCHED) |=> count_reg == $past(count_reg))
        else $error("match count moved without a matched reply");

    a_rtt_only_matched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && verdict_reg != V_MATCHED |-> rtt_reg == '0)
        else $error("round trip set on a non-matched result");

endmodule
